>>> src/fqsr_pkg.sv
package fqsr_pkg;

  // Default sizes of the entry store
  localparam int DEPTH_DEF       = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int HANDLE_BITS_DEF = 16;

  // Fixed widths of the port fields
  localparam int OP_W    = 3;
  localparam int FIELD_W = 16;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_FIND   = 3'd3,
    OP_REMOVE = 3'd4
  } fqsr_op_e;

  // One result transfer as it leaves the sequencer
  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] handle;
    logic               empty;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } fqsr_res_t;

endpackage

>>> src/fqsr_mem.sv
module fqsr_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fqsr_ctrl.sv
module fqsr_ctrl #(
  parameter int DEPTH       = 16,
  parameter int ID_BITS     = 16,
  parameter int HANDLE_BITS = 16,
  parameter int AW          = 4,
  parameter int DW          = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [fqsr_pkg::OP_W-1:0]    opcode_i,
  input  logic [fqsr_pkg::FIELD_W-1:0] proc_id_i,
  input  logic [fqsr_pkg::FIELD_W-1:0] proc_handle_i,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [DW-1:0]             mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [DW-1:0]             mem_rdata_i,
  output logic                      done_o,
  output fqsr_pkg::fqsr_res_t       res_o
);

  import fqsr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e                 state_q;
  logic [OP_W-1:0]        op_q;
  logic [ID_BITS-1:0]     key_q;
  logic [AW-1:0]          head_q;
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          rd_idx_q;
  logic [CW-1:0]          cmp_idx_q;
  logic                   rv_q;
  logic [ID_BITS-1:0]     found_id_q;
  logic [HANDLE_BITS-1:0] found_handle_q;
  logic                   done_q;
  fqsr_res_t              res_q;

  logic [ID_BITS-1:0]     rd_id;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   match;
  logic                   full;

  // Map a queue position onto a physical slot of the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(ofs);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  // Pack one result transfer
  function automatic fqsr_res_t make_res(input logic                   hit,
                                         input logic [ID_BITS-1:0]     id,
                                         input logic [HANDLE_BITS-1:0] handle,
                                         input logic [CW-1:0]          cnt,
                                         input logic                   ovf);
    fqsr_res_t r;
    r.hit      = hit;
    r.id       = FIELD_W'(id);
    r.handle   = FIELD_W'(handle);
    r.empty    = (cnt == '0);
    r.count    = COUNT_W'(cnt);
    r.overflow = ovf;
    return r;
  endfunction

  assign rd_id     = mem_rdata_i[DW-1:HANDLE_BITS];
  assign rd_handle = mem_rdata_i[HANDLE_BITS-1:0];
  assign full      = (count_q == FULL_C);
  assign busy      = (state_q != S_IDLE);

  // Pop and peek take the first entry read; find and remove compare the key
  assign match = rv_q && (state_q == S_SCAN) &&
                 ((op_q == OP_POP) || (op_q == OP_PEEK) || (rd_id == key_q));

  // Memory port control
  always_comb begin
    mem_re_o    = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (rd_idx_q < count_q);
    mem_raddr_o = phys(head_q, rd_idx_q);
    mem_we_o    = 1'b0;
    mem_waddr_o = phys(head_q, count_q);
    mem_wdata_o = {ID_BITS'(proc_id_i), HANDLE_BITS'(proc_handle_i)};
    if (state_q == S_IDLE) begin
      // append at the tail
      mem_we_o = start && (opcode_i == OP_PUSH) && !full;
    end else if (state_q == S_SHIFT) begin
      // move the younger entry one place down
      mem_we_o    = rv_q;
      mem_waddr_o = phys(head_q, cmp_idx_q - ONE_C);
      mem_wdata_o = mem_rdata_i;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      op_q           <= '0;
      key_q          <= '0;
      head_q         <= '0;
      count_q        <= '0;
      rd_idx_q       <= '0;
      cmp_idx_q      <= '0;
      rv_q           <= 1'b0;
      found_id_q     <= '0;
      found_handle_q <= '0;
      done_q         <= 1'b0;
      res_q          <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q     <= opcode_i;
            key_q    <= ID_BITS'(proc_id_i);
            rd_idx_q <= '0;
            rv_q     <= 1'b0;
            case (opcode_i)
              OP_PUSH: begin
                done_q <= 1'b1;
                if (full) begin
                  // drop the entry
                  res_q <= make_res(1'b0, '0, '0, count_q, 1'b1);
                end else begin
                  count_q <= count_q + ONE_C;
                  res_q   <= make_res(1'b0, '0, '0, count_q + ONE_C, 1'b0);
                end
              end
              OP_POP, OP_PEEK, OP_FIND, OP_REMOVE: begin
                if (count_q == '0) begin
                  done_q <= 1'b1;
                  res_q  <= make_res(1'b0, '0, '0, count_q, 1'b0);
                end else begin
                  state_q <= S_SCAN;
                end
              end
              default: begin
                done_q <= 1'b1;
                res_q  <= make_res(1'b0, '0, '0, count_q, 1'b0);
              end
            endcase
          end
        end

        S_SCAN: begin
          // stream reads, compare one entry per cycle
          rv_q      <= mem_re_o;
          cmp_idx_q <= rd_idx_q;
          if (mem_re_o) begin
            rd_idx_q <= rd_idx_q + ONE_C;
          end
          if (match) begin
            found_id_q     <= rd_id;
            found_handle_q <= rd_handle;
            rv_q           <= 1'b0;
            if ((op_q == OP_PEEK) || (op_q == OP_FIND)) begin
              done_q  <= 1'b1;
              res_q   <= make_res(1'b1, rd_id, rd_handle, count_q, 1'b0);
              state_q <= S_IDLE;
            end else if (cmp_idx_q == '0) begin
              // oldest entry leaves: advance the head
              head_q  <= phys(head_q, ONE_C);
              count_q <= count_q - ONE_C;
              done_q  <= 1'b1;
              res_q   <= make_res(1'b1, rd_id, rd_handle, count_q - ONE_C, 1'b0);
              state_q <= S_IDLE;
            end else begin
              rd_idx_q <= cmp_idx_q + ONE_C;
              state_q  <= S_SHIFT;
            end
          end else if (rv_q && (rd_idx_q == count_q)) begin
            // last entry compared without a match
            done_q  <= 1'b1;
            res_q   <= make_res(1'b0, '0, '0, count_q, 1'b0);
            state_q <= S_IDLE;
          end
        end

        S_SHIFT: begin
          // close the gap: read one ahead, write one behind
          rv_q      <= mem_re_o;
          cmp_idx_q <= rd_idx_q;
          if (mem_re_o) begin
            rd_idx_q <= rd_idx_q + ONE_C;
          end
          if (!mem_re_o && !rv_q) begin
            count_q <= count_q - ONE_C;
            done_q  <= 1'b1;
            res_q   <= make_res(1'b1, found_id_q, found_handle_q, count_q - ONE_C, 1'b0);
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> src/fifo_queue_with_key_search_remove_unit.sv
// Push, unused opcodes and any operation on an empty queue give their result in
// the cycle after the start transfer. Pop and peek return the oldest entry, find
// scans the entries for the key, and remove also closes the gap it leaves behind.
// Throughput: one operation at a time; busy holds the next start off until the
// result, and a scan reads one entry per cycle on the single memory read port.
// Reset clears count and head pointer, not the entries; results cannot be stalled.
module fifo_queue_with_key_search_remove_unit #(
  parameter int DEPTH       = fqsr_pkg::DEPTH_DEF,
  parameter int ID_BITS     = fqsr_pkg::ID_BITS_DEF,
  parameter int HANDLE_BITS = fqsr_pkg::HANDLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [fqsr_pkg::OP_W-1:0]    opcode_i,
  input  logic [fqsr_pkg::FIELD_W-1:0] proc_id_i,
  input  logic [fqsr_pkg::FIELD_W-1:0] proc_handle_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [fqsr_pkg::FIELD_W-1:0] out_id_o,
  output logic [fqsr_pkg::FIELD_W-1:0] out_handle_o,
  output logic                         now_empty_o,
  output logic [fqsr_pkg::COUNT_W-1:0] entry_count_o,
  output logic                         overflow_o
);

  import fqsr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int DW = ID_BITS + HANDLE_BITS;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  fqsr_res_t     res;

  // Entry store
  fqsr_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Operation sequencer
  fqsr_ctrl #(
    .DEPTH       (DEPTH),
    .ID_BITS     (ID_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .AW          (AW),
    .DW          (DW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .proc_id_i     (proc_id_i),
    .proc_handle_i (proc_handle_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .done_o        (done_o),
    .res_o         (res)
  );

  // Drive the result fields
  assign hit_o         = res.hit;
  assign out_id_o      = res.id;
  assign out_handle_o  = res.handle;
  assign now_empty_o   = res.empty;
  assign entry_count_o = res.count;
  assign overflow_o    = res.overflow;

  // A transfer either finishes next cycle or keeps the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> done_o || busy)
    else $error("accepted operation neither completed nor held busy");

  // Results only leave once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // A miss returns zeroed entry fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !hit_o |-> (out_id_o == '0) && (out_handle_o == '0))
    else $error("miss with non-zero entry fields");

  // A dropped push never returns an entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && overflow_o |-> !hit_o)
    else $error("overflow together with hit");

endmodule
